// File: hdl/reply_frame_checker_macros.svh
// Assertion macros for the reply frame checker; only rfc_parser includes them.
// Each macro assumes a clock named clk and an active-low reset named rst_n in scope.
`ifndef REPLY_FRAME_CHECKER_MACROS_SVH
`define REPLY_FRAME_CHECKER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define RFC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define RFC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define RFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rfc_pkg.sv
// Shared types and constants for the reply frame checker.
// Used by rfc_parser, rfc_out_buffer and reply_frame_checker; no dependencies.
`timescale 1ns / 1ps

package rfc_pkg;

    localparam logic [7:0] HEADER_VALUE      = 8'hA0;
    localparam int         ERROR_FRAME_TOTAL = 6;
    // An error reply carries a length byte that makes the frame six bytes long.
    localparam logic [7:0] ERROR_LENGTH      = 8'(ERROR_FRAME_TOTAL - 2);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_OK      = 2'd1,
        ST_BAD_SUM = 2'd2,
        ST_ERROR   = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [8:0] position;
        logic       frame_end;
        status_t    status;
        logic       header_bad;
        logic [7:0] error_code;
    } result_t;

endpackage

// File: hdl/rfc_parser.sv
// Frame parser: tracks header, length and body of each reply frame and checks the sum.
// Depends on rfc_pkg and reply_frame_checker_macros.svh.
`timescale 1ns / 1ps
`include "reply_frame_checker_macros.svh"

module rfc_parser
    import rfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output result_t    result
);

    phase_t     phase_reg, phase_next;
    logic [8:0] byte_index_reg, byte_index_next;
    logic [7:0] body_remaining_reg, body_remaining_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic       header_flag_reg, header_flag_next;
    logic [7:0] captured_code_reg, captured_code_next;
    logic       closing;
    logic [7:0] expected_sum;

    always_comb
    begin
        case (phase_reg)
            PH_LENGTH: phase_next = (rx_byte == 8'd0) ? PH_HEADER : PH_BODY;
            PH_BODY:   phase_next = (body_remaining_reg <= 8'd1) ? PH_HEADER : PH_BODY;
            default:   phase_next = PH_LENGTH;
        endcase
    end

    always_comb
    begin
        byte_index_next     = byte_index_reg;
        body_remaining_next = body_remaining_reg;
        frame_length_next   = frame_length_reg;
        running_sum_next    = running_sum_reg;
        header_flag_next    = header_flag_reg;
        captured_code_next  = captured_code_reg;
        closing             = 1'b0;
        case (phase_reg)
            PH_LENGTH:
            begin
                byte_index_next     = 9'd1;
                frame_length_next   = rx_byte;
                body_remaining_next = rx_byte;
                if (rx_byte == 8'd0)
                begin
                    closing = 1'b1;
                end
                else
                begin
                    running_sum_next = running_sum_reg + rx_byte;
                end
            end
            PH_BODY:
            begin
                byte_index_next = byte_index_reg + 9'd1;
                if (byte_index_next == 9'd4)
                begin
                    captured_code_next = rx_byte;
                end
                if (body_remaining_reg <= 8'd1)
                begin
                    body_remaining_next = 8'd0;
                    closing             = 1'b1;
                end
                else
                begin
                    body_remaining_next = body_remaining_reg - 8'd1;
                    running_sum_next    = running_sum_reg + rx_byte;
                end
            end
            default:
            begin
                // A mismatched header is only flagged; the byte still opens the frame.
                byte_index_next     = 9'd0;
                header_flag_next    = (rx_byte != HEADER_VALUE);
                running_sum_next    = rx_byte;
                captured_code_next  = 8'd0;
                frame_length_next   = 8'd0;
                body_remaining_next = 8'd0;
            end
        endcase
    end

    // The last byte must cancel the sum of all earlier bytes of the frame.
    assign expected_sum = 8'd0 - running_sum_reg;

    always_comb
    begin
        result.byte_out   = rx_byte;
        result.position   = byte_index_next;
        result.frame_end  = closing;
        result.header_bad = header_flag_next;
        result.error_code = 8'd0;
        result.status     = ST_BUSY;
        if (closing)
        begin
            if (frame_length_next == ERROR_LENGTH)
            begin
                result.status     = ST_ERROR;
                result.error_code = captured_code_next;
            end
            else if (rx_byte == expected_sum)
            begin
                result.status = ST_OK;
            end
            else
            begin
                result.status = ST_BAD_SUM;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            byte_index_reg     <= 9'd0;
            body_remaining_reg <= 8'd0;
            frame_length_reg   <= 8'd0;
            running_sum_reg    <= 8'd0;
            header_flag_reg    <= 1'b0;
            captured_code_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg          <= phase_next;
            byte_index_reg     <= byte_index_next;
            body_remaining_reg <= body_remaining_next;
            frame_length_reg   <= frame_length_next;
            running_sum_reg    <= running_sum_next;
            header_flag_reg    <= header_flag_next;
            captured_code_reg  <= captured_code_next;
        end
    end

    `RFC_ASSERT_IMPL(a_end_has_status, accept && result.frame_end, result.status != ST_BUSY, "frame end reported without a final status")
    `RFC_ASSERT_NEXT(a_end_restarts, accept && result.frame_end, phase_reg == PH_HEADER, "parser did not return to header after frame end")
    `RFC_ASSERT(a_body_has_bytes, (phase_reg != PH_BODY) || (body_remaining_reg != 8'd0), "body phase with no bytes remaining")
    `RFC_ASSERT_IMPL(a_error_position, accept && (result.status == ST_ERROR), result.position == 9'd5, "error reply closed at the wrong byte")

endmodule

// File: hdl/rfc_out_buffer.sv
// Result register with a skid stage, so one more input request is taken while the output stalls.
// Depends on rfc_pkg.
`timescale 1ns / 1ps

module rfc_out_buffer
    import rfc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    accept;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            // The output slot frees up: the parked request goes first.
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        if (accept)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// File: hdl/reply_frame_checker.sv
// Reply frame checker, a stream of frame bytes in and one annotated result per byte out.
// Instantiates rfc_parser and rfc_out_buffer; depends on rfc_pkg.
//
// Usage:
//   The slave side (s_tvalid, s_tready, s_tdata) takes one reply byte per request.
//   A frame is a header byte (0xA0 expected), a length byte L and L body bytes.
//   The master side gives one result per byte: the byte, its position in the
//   frame and, on the last byte, the status (ok, checksum failed, error reply).
//   m_tlast marks the last byte of a frame. m_tuser carries status and the
//   header mismatch flag; a bad header is only flagged and parsing goes on.
//   Results are registered: the parser works combinationally on each accepted
//   request, and its result goes to the result register, or to the skid stage
//   while the output stalls. Throughput: one byte per cycle while s_tready is high.
//   Stalls: when m_tready is low the result register holds, and one more
//   request is parked in a skid stage; s_tready drops only once that is full.
//   Reset: clears the parser to expect a header and empties both stages.
`timescale 1ns / 1ps

module reply_frame_checker
    import rfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] byte_out, [16:8] position, [24:17] error_code
    output logic        m_tlast,   // frame_end
    output logic [2:0]  m_tuser    // [1:0] status, [2] header_bad
);

    logic    accept;
    result_t parsed;
    result_t buffered;

    assign accept = s_tvalid && s_tready;

    rfc_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .result  (parsed)
    );

    rfc_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (parsed),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buffered)
    );

    assign m_tdata = {7'd0, buffered.error_code, buffered.position, buffered.byte_out};
    assign m_tlast = buffered.frame_end;
    assign m_tuser = {buffered.header_bad, buffered.status};

endmodule
